@@ src/masked_byte_pattern_scan_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern scan unit.
// They expect signals named clk and arst_n in the asserting module.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCAN_UNIT_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCAN_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// mbps_pkg
// Types, constants and register codes shared by the byte pattern scan unit.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int BYTE_W      = 8;
	localparam int ADDR_W      = 64;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int CARE_W      = 16;
	localparam int LEN_REG_W   = 5;
	localparam int PAT_BYTES   = 16;

	// Register indices of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_CARE_MASK      = 3'd2,
		REG_PATTERN_LENGTH = 3'd3,
		REG_BASE_ADDRESS   = 3'd4
	} cfg_reg_e;

	localparam logic [CARE_W-1:0]    CARE_MASK_RST      = '1;
	localparam logic [LEN_REG_W-1:0] PATTERN_LENGTH_RST = 5'd16;

	// One request on the byte stream.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} in_item_t;

	// One request on the result channel.
	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} out_item_t;

	// Control handed to every window cell.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

@@ src/mbps_stream_if.sv @@
// ----------------------------------------------------------------------------
// mbps_stream_if
// Valid/ready channel carrying one payload of a configurable type.
// ----------------------------------------------------------------------------
interface mbps_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ src/masked_byte_pattern_scan_unit.sv @@
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_unit
// Scans a byte stream for the first match of a masked pattern and reports
// once per region: the match start address, or not-found at the last byte.
// ----------------------------------------------------------------------------
//  channel  | direction | payload                      | handshake
//  ---------+-----------+------------------------------+------------
//  stream   | in        | data_byte, last_byte         | valid/ready
//  result   | out       | found, match_address         | valid/ready
//  cfg      | in        | cfg_index, cfg_wdata         | cfg_we only
//
//  One byte is taken every cycle unless the compare stage stalls; the window
//  is a row of cells that shifts once per accepted byte. A taken byte passes
//  the compare stage register, then the result register. The compare stage
//  waits only while the result register is full and unread. Reset empties
//  the window, restores the register reset values and has no clearing pass.
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_scan_unit_macros.svh"

module masked_byte_pattern_scan_unit #(
	parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mbps_stream_if.sink                      stream,
	mbps_stream_if.source                    result,
	input  logic                             cfg_we,
	input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import mbps_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic [BYTE_W-1:0]      pat_al [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] care_al;
	logic [LEN_W-1:0]       len_used;
	logic [ADDR_W-1:0]      base_address;

	logic [BYTE_W-1:0]      win [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] cell_match;
	cell_ctl_t              ctl;

	logic                   valid_s1;
	logic                   last_s1;
	logic [OFFSET_BITS-1:0] cur_s1;

	logic [LEN_W-1:0]       fill_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic                   done_q;

	logic                   res_valid_q;
	logic                   found_q;
	logic [ADDR_W-1:0]      addr_q;

	logic                   in_acc;
	logic                   s1_adv;
	logic                   s1_fire;
	logic                   region_end;
	logic                   hit_s1;
	logic                   res_load;
	logic [LEN_W-1:0]       fill_base;
	logic [OFFSET_BITS-1:0] offset_base;
	logic [ADDR_W-1:0]      addr_s1;

	mbps_cfg #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.pat_al       (pat_al),
		.care_al      (care_al),
		.len_used     (len_used),
		.base_address (base_address)
	);

	// Handshake: the compare stage moves on whenever the result register can
	// take a request, and a new byte enters whenever the stage moves or is empty.
	assign s1_adv       = !res_valid_q || result.ready;
	assign s1_fire      = valid_s1 && s1_adv;
	assign stream.ready = !valid_s1 || s1_adv;
	assign in_acc       = stream.valid && stream.ready;
	assign region_end   = s1_fire && last_s1;

	assign ctl.shift = in_acc;
	assign ctl.clear = region_end;

	// Row of window cells; the newest byte enters the highest cell.
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic [BYTE_W-1:0] feed;
		if (k == PATTERN_MAX - 1) begin : g_top
			assign feed = stream.payload.data_byte;
		end else begin : g_mid
			assign feed = region_end ? '0 : win[k+1];
		end
		mbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.byte_in  (feed),
			.pat_byte (pat_al[k]),
			.care     (care_al[k]),
			.held     (win[k]),
			.match    (cell_match[k])
		);
	end

	// Counters start over when the previous region's last byte leaves.
	assign fill_base   = region_end ? '0 : fill_q;
	assign offset_base = region_end ? '0 : offset_q;

	// Fill count and byte offset, both saturating.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			offset_q <= '0;
		end else if (in_acc) begin
			if (fill_base != LEN_W'(PATTERN_MAX)) begin
				fill_q <= fill_base + LEN_W'(1);
			end else begin
				fill_q <= fill_base;
			end
			if (offset_base != '1) begin
				offset_q <= offset_base + OFFSET_BITS'(1);
			end else begin
				offset_q <= offset_base;
			end
		end else if (region_end) begin
			fill_q   <= '0;
			offset_q <= '0;
		end
	end

	// Compare stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Compare stage payload: the offset of the byte before it was counted.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_s1 <= stream.payload.last_byte;
			cur_s1  <= offset_base;
		end
	end

	// A hit needs at least the pattern length of bytes in the window, no earlier
	// match in this region, and every cell agreeing with its pattern byte.
	assign hit_s1 = valid_s1 && !done_q && (fill_q >= len_used) && (&cell_match);

	// Start address of the match; the current byte is its last byte.
	assign addr_s1 = base_address + ADDR_W'(cur_s1) - ADDR_W'(len_used) + ADDR_W'(1);

	// Region state: a match is reported once, the region end starts afresh.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (region_end) begin
			done_q <= 1'b0;
		end else if (s1_fire && hit_s1) begin
			done_q <= 1'b1;
		end
	end

	// A region that has already matched stays silent at its end.
	assign res_load = s1_fire && !done_q && (hit_s1 || last_s1);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			found_q <= hit_s1;
			addr_q  <= hit_s1 ? addr_s1 : '0;
		end
	end

	assign result.valid                 = res_valid_q;
	assign result.payload.found         = found_q;
	assign result.payload.match_address = addr_q;

	// A match inside a region blocks every later report until the region ends.
	`MBPS_ASSERT_NEXT(a_done_after_hit, s1_fire && hit_s1 && !last_s1, done_q, "done flag not set after a match")
	// A region end with no new byte leaves an empty window count and offset.
	`MBPS_ASSERT_NEXT(a_region_clear, region_end && !in_acc, fill_q == '0 && offset_q == '0 && !done_q, "region state not cleared")
	// A byte in the compare stage has been counted in the window.
	`MBPS_ASSERT_NOW(a_fill_counted, valid_s1, fill_q != '0, "compare stage holds a byte the window never counted")
	// An accepted byte always reaches the compare stage.
	`MBPS_ASSERT_NEXT(a_byte_staged, in_acc, valid_s1, "accepted byte lost before compare")

endmodule

@@ src/mbps_cell.sv @@
// ----------------------------------------------------------------------------
// mbps_cell
// One window slot: holds a byte, passes it on when the window shifts and
// compares it with its aligned pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mbps_pkg::cell_ctl_t       ctl,
	input  logic [mbps_pkg::BYTE_W-1:0] byte_in,
	input  logic [mbps_pkg::BYTE_W-1:0] pat_byte,
	input  logic                      care,
	output logic [mbps_pkg::BYTE_W-1:0] held,
	output logic                      match
);
	import mbps_pkg::*;

	logic [BYTE_W-1:0] held_q;

	// Take the neighbour's byte on a shift, empty the slot at a region end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (ctl.shift) begin
			held_q <= byte_in;
		end else if (ctl.clear) begin
			held_q <= '0;
		end
	end

	// A wildcard slot always matches.
	assign match = !care || (held_q == pat_byte);
	assign held  = held_q;

endmodule

@@ src/mbps_cfg.sv @@
// ----------------------------------------------------------------------------
// mbps_cfg
// Configuration registers, plus the pattern and care bits aligned to the
// window cells, so that the newest cell meets the last pattern byte in use.
// ----------------------------------------------------------------------------
module mbps_cfg #(
	parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
	localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic [mbps_pkg::BYTE_W-1:0]      pat_al [PATTERN_MAX],
	output logic [PATTERN_MAX-1:0]           care_al,
	output logic [LEN_W-1:0]                 len_used,
	output logic [mbps_pkg::ADDR_W-1:0]      base_address
);
	import mbps_pkg::*;

	logic [CFG_DATA_W-1:0] pattern_low_q;
	logic [CFG_DATA_W-1:0] pattern_high_q;
	logic [CARE_W-1:0]     care_mask_q;
	logic [LEN_REG_W-1:0]  pattern_length_q;
	logic [ADDR_W-1:0]     base_address_q;

	logic [BYTE_W-1:0]      pat_al_d [PATTERN_MAX];
	logic [BYTE_W-1:0]      pat_al_q [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] care_al_d;
	logic [PATTERN_MAX-1:0] care_al_q;
	logic [LEN_W-1:0]       len_d;
	logic [LEN_W-1:0]       len_q;

	// Register writes; unknown indices are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			care_mask_q      <= CARE_MASK_RST;
			pattern_length_q <= PATTERN_LENGTH_RST;
			base_address_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_wdata;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_wdata;
				REG_CARE_MASK:      care_mask_q      <= cfg_wdata[CARE_W-1:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_wdata[LEN_REG_W-1:0];
				REG_BASE_ADDRESS:   base_address_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamp the length: zero acts as one, anything above the window as the window.
	always_comb begin
		if (pattern_length_q == '0) begin
			len_d = LEN_W'(1);
		end else if (pattern_length_q > LEN_REG_W'(PATTERN_MAX)) begin
			len_d = LEN_W'(PATTERN_MAX);
		end else begin
			len_d = LEN_W'(pattern_length_q);
		end
	end

	// Cell k meets pattern byte k + len - PATTERN_MAX; cells before the
	// pattern start are wildcards.
	always_comb begin
		int j;
		logic [2*CFG_DATA_W-1:0] pattern;
		logic [3:0] idx;
		pattern = {pattern_high_q, pattern_low_q};
		for (int k = 0; k < PATTERN_MAX; k++) begin
			j   = k + int'(len_d) - PATTERN_MAX;
			idx = j[3:0];
			if (j >= 0) begin
				pat_al_d[k]  = pattern[idx*BYTE_W +: BYTE_W];
				care_al_d[k] = care_mask_q[idx];
			end else begin
				pat_al_d[k]  = '0;
				care_al_d[k] = 1'b0;
			end
		end
	end

	// The aligned view is refreshed every cycle; reset gives the aligned
	// form of the reset registers (full length, every byte cared for, zero).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				pat_al_q[k] <= '0;
			end
			care_al_q <= '1;
			len_q     <= LEN_W'(PATTERN_MAX);
		end else begin
			pat_al_q  <= pat_al_d;
			care_al_q <= care_al_d;
			len_q     <= len_d;
		end
	end

	assign pat_al       = pat_al_q;
	assign care_al      = care_al_q;
	assign len_used     = len_q;
	assign base_address = base_address_q;

endmodule
